@@ sv/gms_pkg.sv @@
// Shared types, codes and field layout for the gimbal mode supervisor.
// Used by gms_next_mode, gimbal_mode_supervisor and gms_checker.
package gms_pkg;

  localparam int TICK_BITS   = 32;
  localparam int TARGET_BITS = 64;

  typedef enum logic [2:0] {
    MODE_DISABLE = 3'd0,
    MODE_STARTUP = 3'd1,
    MODE_MANUAL  = 3'd2,
    MODE_AIMBOT  = 3'd3,
    MODE_REALIGN = 3'd4,
    MODE_YAWCTR  = 3'd5,
    MODE_FFVER   = 3'd6,
    MODE_IDENT   = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    WHY_NONE      = 3'd0,
    WHY_INIT      = 3'd1,
    WHY_REQ       = 3'd2,
    WHY_LOST      = 3'd3,
    WHY_RECOV     = 3'd4,
    WHY_FALL      = 3'd5,
    WHY_REACHED   = 3'd6,
    WHY_POWER_OFF = 3'd7
  } why_t;

  typedef enum logic [1:0] {
    PROF_NORMAL = 2'd0,
    PROF_FFVER  = 2'd1,
    PROF_IDENT  = 2'd2
  } profile_t;

  // Request flags that steer the mode transition.
  typedef struct packed {
    logic  input_ok;
    mode_t wanted_mode;
    logic  yaw_center_needed;
    logic  chassis_fallen;
    logic  startup_done;
  } req_t;

  // Transition decision for one frame.
  typedef struct packed {
    logic  move;
    mode_t mode;
    why_t  why;
  } trans_t;

  // Input item layout, lowest bit first.
  localparam int IN_OK_LSB    = 0;
  localparam int IN_WANT_LSB  = 1;
  localparam int IN_YAW_LSB   = 4;
  localparam int IN_FALL_LSB  = 5;
  localparam int IN_DONE_LSB  = 6;
  localparam int IN_PREF_LSB  = 7;
  localparam int IN_HOK_LSB   = 8;
  localparam int IN_HAIM_LSB  = 9;
  localparam int IN_RAIM_LSB  = IN_HAIM_LSB + TARGET_BITS;
  localparam int IN_NOW_LSB   = IN_RAIM_LSB + TARGET_BITS;
  localparam int IN_BITS      = IN_NOW_LSB + TICK_BITS;
  localparam int IN_W         = ((IN_BITS + 7) / 8) * 8;

  // Result item layout, lowest bit first.
  localparam int OUT_MODE_LSB = 0;
  localparam int OUT_CHG_LSB  = 3;
  localparam int OUT_WHY_LSB  = 4;
  localparam int OUT_ELA_LSB  = 7;
  localparam int OUT_DRV_LSB  = OUT_ELA_LSB + TICK_BITS;
  localparam int OUT_ALN_LSB  = OUT_DRV_LSB + 1;
  localparam int OUT_YFB_LSB  = OUT_ALN_LSB + 1;
  localparam int OUT_HOST_LSB = OUT_YFB_LSB + 1;
  localparam int OUT_AIM_LSB  = OUT_HOST_LSB + 1;
  localparam int OUT_PROF_LSB = OUT_AIM_LSB + TARGET_BITS;
  localparam int OUT_BITS     = OUT_PROF_LSB + 2;
  localparam int OUT_W        = ((OUT_BITS + 7) / 8) * 8;

endpackage

@@ sv/gms_next_mode.sv @@
// Per-mode priority rules of the gimbal mode supervisor.
// Depends on gms_pkg for the mode, reason and request types.
module gms_next_mode
  import gms_pkg::*;
(
  input  mode_t  cur_mode,
  input  req_t   req,
  output trans_t trans
);

  logic  dis_hit;
  why_t  dis_why;
  logic  safe_hit;
  mode_t safe_mode;
  why_t  safe_why;

  // Disable first, then yaw centering, then chassis fall.
  always_comb begin
    dis_hit   = !req.input_ok || (req.wanted_mode == MODE_DISABLE);
    dis_why   = req.input_ok ? WHY_REQ : WHY_LOST;
    safe_hit  = 1'b1;
    safe_mode = MODE_DISABLE;
    safe_why  = dis_why;
    if (dis_hit) begin
      safe_mode = MODE_DISABLE;
    end else if (req.yaw_center_needed) begin
      safe_mode = MODE_YAWCTR;
      safe_why  = WHY_RECOV;
    end else if (req.chassis_fallen) begin
      safe_mode = MODE_REALIGN;
      safe_why  = WHY_FALL;
    end else begin
      safe_hit = 1'b0;
    end
  end

  always_comb begin
    trans = '{move: 1'b0, mode: cur_mode, why: WHY_NONE};
    case (cur_mode)
      MODE_DISABLE: begin
        if (dis_hit) begin
          trans.move = 1'b0;
        end else if (safe_hit) begin
          trans = '{move: 1'b1, mode: safe_mode, why: safe_why};
        end else if (req.wanted_mode == MODE_IDENT) begin
          trans = '{move: 1'b1, mode: MODE_IDENT, why: WHY_REQ};
        end else if (req.wanted_mode == MODE_FFVER) begin
          trans = '{move: 1'b1, mode: MODE_FFVER, why: WHY_REQ};
        end else begin
          trans = '{move: 1'b1, mode: MODE_STARTUP, why: WHY_REQ};
        end
      end
      MODE_STARTUP, MODE_MANUAL, MODE_AIMBOT: begin
        if (safe_hit) begin
          trans = '{move: 1'b1, mode: safe_mode, why: safe_why};
        end else if (req.wanted_mode == MODE_IDENT) begin
          trans = '{move: 1'b1, mode: MODE_IDENT, why: WHY_REQ};
        end else if (req.wanted_mode == MODE_FFVER) begin
          trans = '{move: 1'b1, mode: MODE_FFVER, why: WHY_REQ};
        end else if (cur_mode == MODE_STARTUP) begin
          if (req.startup_done) begin
            trans = '{move: 1'b1,
                      mode: (req.wanted_mode == MODE_AIMBOT) ? MODE_AIMBOT : MODE_MANUAL,
                      why: WHY_REACHED};
          end
        end else if (cur_mode == MODE_MANUAL) begin
          if (req.wanted_mode == MODE_AIMBOT) begin
            trans = '{move: 1'b1, mode: MODE_AIMBOT, why: WHY_REQ};
          end
        end else begin
          if (req.wanted_mode != MODE_AIMBOT) begin
            trans = '{move: 1'b1, mode: MODE_MANUAL, why: WHY_REQ};
          end
        end
      end
      MODE_REALIGN: begin
        if (dis_hit) begin
          trans = '{move: 1'b1, mode: MODE_DISABLE, why: dis_why};
        end else if (req.yaw_center_needed) begin
          trans = '{move: 1'b1, mode: MODE_YAWCTR, why: WHY_RECOV};
        end else if (!req.chassis_fallen) begin
          trans = '{move: 1'b1, mode: MODE_STARTUP, why: WHY_REACHED};
        end
      end
      MODE_YAWCTR: begin
        if (dis_hit) begin
          trans = '{move: 1'b1, mode: MODE_DISABLE, why: dis_why};
        end else if (req.yaw_center_needed) begin
          trans.move = 1'b0;
        end else if (req.chassis_fallen) begin
          trans = '{move: 1'b1, mode: MODE_REALIGN, why: WHY_REACHED};
        end else begin
          trans = '{move: 1'b1, mode: MODE_STARTUP, why: WHY_REACHED};
        end
      end
      MODE_FFVER: begin
        if (safe_hit) begin
          trans = '{move: 1'b1, mode: safe_mode, why: safe_why};
        end else if (req.wanted_mode != MODE_FFVER) begin
          trans = '{move: 1'b1,
                    mode: (req.wanted_mode == MODE_IDENT) ? MODE_IDENT : MODE_STARTUP,
                    why: WHY_REQ};
        end
      end
      MODE_IDENT: begin
        if (safe_hit) begin
          trans = '{move: 1'b1, mode: safe_mode, why: safe_why};
        end else if (req.wanted_mode != MODE_IDENT) begin
          trans = '{move: 1'b1,
                    mode: (req.wanted_mode == MODE_FFVER) ? MODE_FFVER : MODE_STARTUP,
                    why: WHY_REQ};
        end
      end
      default: begin
        trans = '{move: 1'b0, mode: cur_mode, why: WHY_NONE};
      end
    endcase
  end

endmodule

@@ sv/gimbal_mode_supervisor.sv @@
// Top level of the gimbal mode supervisor: input register, mode state and result register.
// Depends on gms_pkg and gms_next_mode.
//
// Usage: each item on the s_ channel is one control-frame request; each request yields
// exactly one result item on the m_ channel, in order. The block holds the current gimbal
// mode and the tick at which that mode was entered, and applies the per-mode priority
// rules (disable or input loss, yaw centering, chassis fall, test requests, operator
// modes), making at most one transition per frame.
// An accepted item is held in the input register; the transition logic then writes the
// mode state and the result register, whose item is then shown on m_tdata.
// Throughput is one item per cycle while m_tready stays high; the mode state is updated
// as each item leaves the input register, so the next item already sees the new mode.
// Reset (synchronous, active high) empties both registers, returns the mode to disable
// and clears the entry tick to zero.
// When the receiver stalls, the result holds on m_tdata; the input register keeps taking
// one more item, and s_tready drops only while both registers are full and m_tready is low.
module gimbal_mode_supervisor
  import gms_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  // From bit 0: input_ok, wanted_mode, yaw_center_needed, chassis_fallen, startup_done,
  // prefer_host, host_ok, host_aim, rc_aim, now_ms, zero fill.
  input  logic [IN_W-1:0]  s_tdata,
  output logic             m_tvalid,
  input  logic             m_tready,
  // From bit 0: mode, mode_changed, why, elapsed_ms, drive_enable, align_forward,
  // yaw_motor_feedback, source_is_host, aim, profile code, zero fill.
  output logic [OUT_W-1:0] m_tdata
);

  // Input register.
  logic               in_valid;
  logic [IN_BITS-1:0] in_data;

  // Mode state.
  mode_t                cur_mode;
  mode_t                cur_mode_next;
  logic [TICK_BITS-1:0] enter_tick;
  logic [TICK_BITS-1:0] enter_tick_next;

  // Result register.
  logic                  out_valid;
  logic [OUT_BITS-1:0]   out_data;
  logic [OUT_BITS-1:0]   out_data_next;

  logic                   out_free;
  logic                   advance;
  req_t                   req;
  trans_t                 trans;
  logic                   prefer_host;
  logic                   host_ok;
  logic [TARGET_BITS-1:0] host_aim;
  logic [TARGET_BITS-1:0] rc_aim;
  logic [TICK_BITS-1:0]   now_ms;
  logic [TICK_BITS-1:0]   elapsed_ms;
  logic                   source_is_host;
  profile_t               profile_code;

  assign out_free = !out_valid || m_tready;
  assign advance  = in_valid && out_free;
  assign s_tready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      in_data <= s_tdata[IN_BITS-1:0];
    end
  end

  // Unpack the held request.
  always_comb begin
    req.input_ok          = in_data[IN_OK_LSB];
    req.wanted_mode       = mode_t'(in_data[IN_WANT_LSB +: 3]);
    req.yaw_center_needed = in_data[IN_YAW_LSB];
    req.chassis_fallen    = in_data[IN_FALL_LSB];
    req.startup_done      = in_data[IN_DONE_LSB];
  end
  assign prefer_host = in_data[IN_PREF_LSB];
  assign host_ok     = in_data[IN_HOK_LSB];
  assign host_aim    = in_data[IN_HAIM_LSB +: TARGET_BITS];
  assign rc_aim      = in_data[IN_RAIM_LSB +: TARGET_BITS];
  assign now_ms      = in_data[IN_NOW_LSB +: TICK_BITS];

  gms_next_mode u_next_mode (
    .cur_mode (cur_mode),
    .req      (req),
    .trans    (trans)
  );

  // A transition restarts the entry tick, so elapsed time reads zero on that frame.
  always_comb begin
    cur_mode_next   = trans.move ? trans.mode : cur_mode;
    enter_tick_next = trans.move ? now_ms : enter_tick;
    elapsed_ms      = now_ms - enter_tick_next;
    source_is_host  = (cur_mode_next == MODE_AIMBOT) && prefer_host && host_ok;
    case (cur_mode_next)
      MODE_FFVER: profile_code = PROF_FFVER;
      MODE_IDENT: profile_code = PROF_IDENT;
      default:    profile_code = PROF_NORMAL;
    endcase
    out_data_next = {
      profile_code,
      source_is_host ? host_aim : rc_aim,
      source_is_host,
      (cur_mode_next == MODE_STARTUP) || (cur_mode_next == MODE_YAWCTR) ||
        (cur_mode_next == MODE_FFVER) || (cur_mode_next == MODE_IDENT),
      cur_mode_next == MODE_REALIGN,
      cur_mode_next != MODE_DISABLE,
      elapsed_ms,
      trans.move ? trans.why : WHY_NONE,
      trans.move,
      cur_mode_next
    };
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_mode   <= MODE_DISABLE;
      enter_tick <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (advance) begin
        cur_mode   <= cur_mode_next;
        enter_tick <= enter_tick_next;
      end
      if (out_free) begin
        out_valid <= in_valid;
      end
    end
    if (advance) begin
      out_data <= out_data_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_W'(out_data);

endmodule

@@ sv/gms_checker.sv @@
// Port-level checks for the gimbal mode supervisor, bound to the top level.
// Depends on gms_pkg for the result layout and mode codes.
module gms_checker
  import gms_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  logic [2:0] mode;
  logic       changed;
  logic [2:0] why;
  logic       drive;
  logic       host;

  assign mode    = m_tdata[OUT_MODE_LSB +: 3];
  assign changed = m_tdata[OUT_CHG_LSB];
  assign why     = m_tdata[OUT_WHY_LSB +: 3];
  assign drive   = m_tdata[OUT_DRV_LSB];
  assign host    = m_tdata[OUT_HOST_LSB];

  // A transition restarts the elapsed count.
  a_changed_elapsed: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && changed |-> m_tdata[OUT_ELA_LSB +: TICK_BITS] == '0)
    else $error("elapsed time not zero on a mode change");

  // A reason is given exactly when the mode changes.
  a_reason: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (changed == (why != WHY_NONE)))
    else $error("reason code and change flag disagree");

  a_drive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (drive == (mode != MODE_DISABLE)))
    else $error("drive enable does not follow the mode");

  a_host_only_aimbot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && host |-> mode == MODE_AIMBOT)
    else $error("host target selected outside aimbot mode");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind gimbal_mode_supervisor gms_checker u_gms_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ tb/tb_gimbal_mode_supervisor.sv @@
// Self-checking testbench for gimbal_mode_supervisor: directed mode walks, weighted random
// control frames, random idling on both streams and a long receiver hold-off.
// Depends on gms_pkg and the gimbal_mode_supervisor RTL.
module tb_gimbal_mode_supervisor;
  import gms_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int HOLD_CYCLES  = 120;

  typedef struct {
    logic                   link_ok;
    mode_t                  want;
    logic                   yaw_req;
    logic                   fallen;
    logic                   aligned;
    logic                   prefer_host;
    logic                   host_ok;
    logic [TARGET_BITS-1:0] host_aim;
    logic [TARGET_BITS-1:0] rc_aim;
    logic [TICK_BITS-1:0]   now_ms;
  } frame_t;

  typedef struct {
    mode_t                  mode;
    logic                   changed;
    why_t                   why;
    logic [TICK_BITS-1:0]   elapsed;
    logic                   drive;
    logic                   align;
    logic                   yaw_fb;
    logic                   from_host;
    logic [TARGET_BITS-1:0] aim;
    profile_t               profile;
  } status_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;

  gimbal_mode_supervisor dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  status_t              expected_status[$];
  int unsigned          fail_count = 0;
  int unsigned          results_seen = 0;
  int unsigned          send_gap_pct = 0;
  int unsigned          recv_gap_pct = 0;
  int unsigned          hold_request = 0;
  int unsigned          hold_left = 0;
  int unsigned          quiet_cycles = 0;
  logic [TICK_BITS-1:0] tick_now = '0;

  // Mode tracker state, mirrors the block after reset.
  mode_t                sup_mode = MODE_DISABLE;
  logic [TICK_BITS-1:0] sup_entered = '0;
  logic                 move_taken;
  mode_t                move_target;
  why_t                 move_reason;

  // A transition to the mode already held does not count, so later rules still get a say.
  function automatic void propose(mode_t m, why_t w);
    if (m != sup_mode) begin
      move_taken  = 1'b1;
      move_target = m;
      move_reason = w;
    end
  endfunction

  // Disable or link loss, then yaw centering, then chassis fall.
  function automatic void safety_claims(frame_t f);
    if (!f.link_ok) propose(MODE_DISABLE, WHY_LOST);
    else if (f.want == MODE_DISABLE) propose(MODE_DISABLE, WHY_REQ);
    else if (f.yaw_req) propose(MODE_YAWCTR, WHY_RECOV);
    else if (f.fallen) propose(MODE_REALIGN, WHY_FALL);
  endfunction

  function automatic void test_claims(frame_t f);
    if (f.want == MODE_IDENT) propose(MODE_IDENT, WHY_REQ);
    else if (f.want == MODE_FFVER) propose(MODE_FFVER, WHY_REQ);
  endfunction

  // Runs one control frame through the mode rules and returns the status it produces.
  function automatic status_t supervise_frame(frame_t f);
    status_t s;
    logic    via_host;
    move_taken  = 1'b0;
    move_target = sup_mode;
    move_reason = WHY_NONE;
    case (sup_mode)
      MODE_DISABLE: begin
        if (f.link_ok && f.want != MODE_DISABLE) begin
          if (f.yaw_req) propose(MODE_YAWCTR, WHY_RECOV);
          else if (f.fallen) propose(MODE_REALIGN, WHY_FALL);
          else begin
            test_claims(f);
            if (!move_taken) propose(MODE_STARTUP, WHY_REQ);
          end
        end
      end
      MODE_STARTUP: begin
        safety_claims(f);
        if (!move_taken) test_claims(f);
        if (!move_taken && f.aligned) begin
          if (f.want == MODE_AIMBOT) propose(MODE_AIMBOT, WHY_REACHED);
          else propose(MODE_MANUAL, WHY_REACHED);
        end
      end
      MODE_MANUAL: begin
        safety_claims(f);
        if (!move_taken) test_claims(f);
        if (!move_taken && f.want == MODE_AIMBOT) propose(MODE_AIMBOT, WHY_REQ);
      end
      MODE_AIMBOT: begin
        safety_claims(f);
        if (!move_taken) test_claims(f);
        if (!move_taken && f.want != MODE_AIMBOT) propose(MODE_MANUAL, WHY_REQ);
      end
      MODE_REALIGN: begin
        if (!f.link_ok) propose(MODE_DISABLE, WHY_LOST);
        else if (f.want == MODE_DISABLE) propose(MODE_DISABLE, WHY_REQ);
        else if (f.yaw_req) propose(MODE_YAWCTR, WHY_RECOV);
        else if (!f.fallen) propose(MODE_STARTUP, WHY_REACHED);
      end
      MODE_YAWCTR: begin
        if (!f.link_ok) propose(MODE_DISABLE, WHY_LOST);
        else if (f.want == MODE_DISABLE) propose(MODE_DISABLE, WHY_REQ);
        else if (!f.yaw_req) begin
          if (f.fallen) propose(MODE_REALIGN, WHY_REACHED);
          else propose(MODE_STARTUP, WHY_REACHED);
        end
      end
      MODE_FFVER: begin
        safety_claims(f);
        if (!move_taken && f.want != MODE_FFVER) begin
          if (f.want == MODE_IDENT) propose(MODE_IDENT, WHY_REQ);
          else propose(MODE_STARTUP, WHY_REQ);
        end
      end
      MODE_IDENT: begin
        safety_claims(f);
        if (!move_taken && f.want != MODE_IDENT) begin
          if (f.want == MODE_FFVER) propose(MODE_FFVER, WHY_REQ);
          else propose(MODE_STARTUP, WHY_REQ);
        end
      end
      default: begin
      end
    endcase

    if (move_taken) begin
      sup_mode    = move_target;
      sup_entered = f.now_ms;
    end

    via_host    = (sup_mode == MODE_AIMBOT) && f.prefer_host && f.host_ok;
    s.mode      = sup_mode;
    s.changed   = move_taken;
    s.why       = move_reason;
    s.elapsed   = f.now_ms - sup_entered;
    s.drive     = (sup_mode != MODE_DISABLE);
    s.align     = (sup_mode == MODE_REALIGN);
    s.yaw_fb    = (sup_mode == MODE_STARTUP) || (sup_mode == MODE_YAWCTR) ||
                  (sup_mode == MODE_FFVER) || (sup_mode == MODE_IDENT);
    s.from_host = via_host;
    s.aim       = via_host ? f.host_aim : f.rc_aim;
    if (sup_mode == MODE_FFVER) s.profile = PROF_FFVER;
    else if (sup_mode == MODE_IDENT) s.profile = PROF_IDENT;
    else s.profile = PROF_NORMAL;
    return s;
  endfunction

  function automatic logic [IN_W-1:0] pack_frame(frame_t f);
    logic [IN_W-1:0] d;
    d = '0;
    d[IN_OK_LSB]                      = f.link_ok;
    d[IN_WANT_LSB +: 3]               = f.want;
    d[IN_YAW_LSB]                     = f.yaw_req;
    d[IN_FALL_LSB]                    = f.fallen;
    d[IN_DONE_LSB]                    = f.aligned;
    d[IN_PREF_LSB]                    = f.prefer_host;
    d[IN_HOK_LSB]                     = f.host_ok;
    d[IN_HAIM_LSB +: TARGET_BITS]     = f.host_aim;
    d[IN_RAIM_LSB +: TARGET_BITS]     = f.rc_aim;
    d[IN_NOW_LSB +: TICK_BITS]        = f.now_ms;
    return d;
  endfunction

  function automatic status_t unpack_status(logic [OUT_W-1:0] d);
    status_t s;
    s.mode      = mode_t'(d[OUT_MODE_LSB +: 3]);
    s.changed   = d[OUT_CHG_LSB];
    s.why       = why_t'(d[OUT_WHY_LSB +: 3]);
    s.elapsed   = d[OUT_ELA_LSB +: TICK_BITS];
    s.drive     = d[OUT_DRV_LSB];
    s.align     = d[OUT_ALN_LSB];
    s.yaw_fb    = d[OUT_YFB_LSB];
    s.from_host = d[OUT_HOST_LSB];
    s.aim       = d[OUT_AIM_LSB +: TARGET_BITS];
    s.profile   = profile_t'(d[OUT_PROF_LSB +: 2]);
    return s;
  endfunction

  function automatic void check_field(string name, logic [63:0] due, logic [63:0] seen);
    if (due !== seen) begin
      fail_count++;
      if (fail_count <= 10)
        $display("result %0d: %s expected %h, got %h", results_seen, name, due, seen);
    end
  endfunction

  // Frame with chosen control flags; the aims and host flags are random and the tick
  // moves on a little each frame.
  function automatic frame_t cmd(logic ok, mode_t want, logic yaw, logic fall, logic done);
    frame_t f;
    tick_now      += 7;
    f.link_ok     = ok;
    f.want        = want;
    f.yaw_req     = yaw;
    f.fallen      = fall;
    f.aligned     = done;
    f.prefer_host = 1'($urandom_range(1));
    f.host_ok     = 1'($urandom_range(1));
    f.host_aim    = {$urandom, $urandom};
    f.rc_aim      = {$urandom, $urandom};
    f.now_ms      = tick_now;
    return f;
  endfunction

  // Mostly plausible operator traffic: link up, rare recovery events, modes weighted
  // toward manual and aimbot. One frame in ten is uniform noise.
  function automatic frame_t random_frame();
    frame_t      f;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 70) tick_now += $urandom_range(1, 20);
    else if (r >= 90) tick_now = $urandom;
    r = $urandom_range(99);
    if (r < 6) f.want = MODE_DISABLE;
    else if (r < 22) f.want = MODE_STARTUP;
    else if (r < 50) f.want = MODE_MANUAL;
    else if (r < 74) f.want = MODE_AIMBOT;
    else if (r < 78) f.want = MODE_REALIGN;
    else if (r < 82) f.want = MODE_YAWCTR;
    else if (r < 91) f.want = MODE_FFVER;
    else f.want = MODE_IDENT;
    f.link_ok     = ($urandom_range(99) >= 4);
    f.yaw_req     = ($urandom_range(99) < 6);
    f.fallen      = ($urandom_range(99) < 8);
    f.aligned     = ($urandom_range(99) < 55);
    f.prefer_host = 1'($urandom_range(1));
    f.host_ok     = 1'($urandom_range(1));
    f.host_aim    = {$urandom, $urandom};
    f.rc_aim      = {$urandom, $urandom};
    f.now_ms      = tick_now;
    if ($urandom_range(9) == 0) begin
      f.link_ok = 1'($urandom_range(1));
      f.want    = mode_t'($urandom_range(7));
      f.yaw_req = 1'($urandom_range(1));
      f.fallen  = 1'($urandom_range(1));
      f.aligned = 1'($urandom_range(1));
    end
    return f;
  endfunction

  // Offers one item, possibly after random gaps, and records its expected status once
  // the block takes it.
  task automatic send_frame(input frame_t f);
    @(negedge clk);
    while ($urandom_range(99) < send_gap_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= pack_frame(f);
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    expected_status.push_back(supervise_frame(f));
  endtask

  // Receiver: random stalls, or a counted hold-off when one is requested.
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  always @(posedge clk) begin
    status_t seen;
    status_t due;
    if (!rst && m_tvalid && m_tready) begin
      seen = unpack_status(m_tdata);
      if (expected_status.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) $display("result %0d arrived with nothing pending", results_seen);
      end else begin
        due = expected_status.pop_front();
        check_field("mode", 64'(due.mode), 64'(seen.mode));
        check_field("mode_changed", 64'(due.changed), 64'(seen.changed));
        check_field("why", 64'(due.why), 64'(seen.why));
        check_field("elapsed_ms", 64'(due.elapsed), 64'(seen.elapsed));
        check_field("drive_enable", 64'(due.drive), 64'(seen.drive));
        check_field("align_forward", 64'(due.align), 64'(seen.align));
        check_field("yaw_motor_feedback", 64'(due.yaw_fb), 64'(seen.yaw_fb));
        check_field("source_is_host", 64'(due.from_host), 64'(seen.from_host));
        check_field("aim", due.aim, seen.aim);
        check_field("profile", 64'(due.profile), 64'(seen.profile));
      end
      results_seen++;
    end
  end

  // Watchdog: the run is stuck if neither stream moves for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("gimbal_mode_supervisor regression: fail");
        $finish;
      end
    end
  end

  // Walks every mode and every transition reason that the block produces at least once.
  task automatic test_mode_walk();
    frame_t f;
    f = cmd(1'b0, MODE_MANUAL, 1'b0, 1'b0, 1'b0);    // link down in disable: no move
    f.now_ms = '0;
    f.host_aim = '1;
    f.rc_aim = '0;
    send_frame(f);
    f = cmd(1'b1, MODE_DISABLE, 1'b0, 1'b0, 1'b0);   // disable while disabled
    f.host_aim = '0;
    f.rc_aim = '1;
    send_frame(f);
    send_frame(cmd(1'b1, MODE_REALIGN, 1'b0, 1'b0, 1'b0)); // falls back to startup
    send_frame(cmd(1'b1, MODE_MANUAL, 1'b0, 1'b0, 1'b0));
    f = cmd(1'b1, MODE_AIMBOT, 1'b0, 1'b0, 1'b1);    // aligned, into aimbot on host aim
    f.prefer_host = 1'b1;
    f.host_ok = 1'b1;
    f.host_aim = '1;
    send_frame(f);
    f = cmd(1'b1, MODE_AIMBOT, 1'b0, 1'b0, 1'b0);    // host preferred but not valid
    f.prefer_host = 1'b1;
    f.host_ok = 1'b0;
    send_frame(f);
    send_frame(cmd(1'b1, MODE_YAWCTR, 1'b0, 1'b0, 1'b0));  // aimbot falls back to manual
    send_frame(cmd(1'b1, MODE_REALIGN, 1'b0, 1'b0, 1'b0)); // manual stays
    send_frame(cmd(1'b1, MODE_AIMBOT, 1'b0, 1'b0, 1'b0));
    send_frame(cmd(1'b1, MODE_FFVER, 1'b0, 1'b0, 1'b0));
    send_frame(cmd(1'b1, MODE_IDENT, 1'b0, 1'b0, 1'b0));
    send_frame(cmd(1'b1, MODE_FFVER, 1'b0, 1'b0, 1'b0));
    send_frame(cmd(1'b1, MODE_MANUAL, 1'b0, 1'b0, 1'b0));
    send_frame(cmd(1'b1, MODE_IDENT, 1'b0, 1'b0, 1'b0));
    send_frame(cmd(1'b1, MODE_REALIGN, 1'b0, 1'b0, 1'b0));
    // Push the tick up to its top so the next elapsed values wrap.
    tick_now = {TICK_BITS{1'b1}} - 7;
    send_frame(cmd(1'b1, MODE_MANUAL, 1'b0, 1'b1, 1'b0));  // fall into realign
    send_frame(cmd(1'b1, MODE_MANUAL, 1'b0, 1'b1, 1'b0));
    send_frame(cmd(1'b1, MODE_MANUAL, 1'b1, 1'b1, 1'b0));  // yaw centering wins
    send_frame(cmd(1'b1, MODE_MANUAL, 1'b1, 1'b0, 1'b0));
    send_frame(cmd(1'b1, MODE_MANUAL, 1'b0, 1'b1, 1'b0));  // centered, still fallen
    send_frame(cmd(1'b1, MODE_MANUAL, 1'b0, 1'b0, 1'b0));
    send_frame(cmd(1'b1, MODE_MANUAL, 1'b0, 1'b0, 1'b1));
    send_frame(cmd(1'b1, MODE_DISABLE, 1'b0, 1'b0, 1'b0)); // requested disable
    send_frame(cmd(1'b1, MODE_IDENT, 1'b0, 1'b0, 1'b0));
    send_frame(cmd(1'b0, MODE_IDENT, 1'b0, 1'b0, 1'b0));   // link lost
    send_frame(cmd(1'b1, MODE_MANUAL, 1'b1, 1'b0, 1'b0));
    send_frame(cmd(1'b0, MODE_MANUAL, 1'b1, 1'b0, 1'b0));
    send_frame(cmd(1'b1, MODE_FFVER, 1'b0, 1'b1, 1'b0));
  endtask

  task automatic test_random_frames(input int unsigned count, input int unsigned send_pct,
                                    input int unsigned recv_pct);
    send_gap_pct = send_pct;
    recv_gap_pct = recv_pct;
    repeat (count) send_frame(random_frame());
  endtask

  // The receiver stops for a long stretch while items keep coming, so the block fills up
  // and has to hold off its input. The last offer is withdrawn first so that it is not
  // taken a second time.
  task automatic test_receiver_hold();
    send_gap_pct = 0;
    recv_gap_pct = 0;
    @(negedge clk);
    s_tvalid <= 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (30) send_frame(random_frame());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_mode_walk();
    test_random_frames(300, 36, 47);
    tick_now = {TICK_BITS{1'b1}} - 300;
    test_random_frames(300, 47, 36);
    test_receiver_hold();
    test_random_frames(300, 0, 0);

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("gimbal_mode_supervisor regression: pass");
    end else begin
      $display("gimbal_mode_supervisor regression: fail");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/gms_pkg.sv
sv/gms_next_mode.sv
sv/gimbal_mode_supervisor.sv
sv/gms_checker.sv
tb/tb_gimbal_mode_supervisor.sv
